>>> hw/rtl/pdc_pkg.sv
// Package for the wind and rain pulse debounce counter.
// Holds the event and register codes, reset values and the structs shared
// by pdc_cfg, pdc_eval and the top level. No dependencies.
`default_nettype none

package pdc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CfgIdxW = 2;

  // event codes
  localparam logic [OpW-1:0] OP_WIND  = 2'd0;
  localparam logic [OpW-1:0] OP_RAIN  = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd2;
  localparam logic [OpW-1:0] OP_START = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIND_HOLDOFF = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RAIN_HOLDOFF = 2'd2;

  localparam logic [DataW-1:0] WIND_HOLDOFF_RST = 32'd10000;
  localparam logic [DataW-1:0] RAIN_HOLDOFF_RST = 32'd100000;
  localparam logic [DataW-1:0] GAP_NONE         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             enable;
    logic [DataW-1:0] wind_holdoff_us;
    logic [DataW-1:0] rain_holdoff_us;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] wind_count;
    logic [DataW-1:0] rain_count;
    logic [DataW-1:0] shortest_gap_us;
    logic             accepted;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/pdc_cfg.sv
// Configuration registers of the pulse debounce counter.
// Plain write port, no read-back. Depends on pdc_pkg.
`default_nettype none

module pdc_cfg
  import pdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [DataW-1:0]   cfg_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE:       cfg_nxt.enable          = cfg_data[0];
        REG_WIND_HOLDOFF: cfg_nxt.wind_holdoff_us = cfg_data;
        REG_RAIN_HOLDOFF: cfg_nxt.rain_holdoff_us = cfg_data;
        default:          cfg_nxt = cfg_r;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b1;
      cfg_r.wind_holdoff_us <= WIND_HOLDOFF_RST;
      cfg_r.rain_holdoff_us <= RAIN_HOLDOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/pdc_eval.sv
// Counter state and per-item evaluation of the pulse debounce counter.
// Updates counts, edge times and the shortest wind gap, and registers the
// result item. Depends on pdc_pkg.
`default_nettype none

module pdc_eval
  import pdc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             go,
  input  wire logic [OpW-1:0]   op,
  input  wire logic [DataW-1:0] time_us,
  output res_t                  res
);

  logic [DataW-1:0] wind_total_r, wind_total_nxt;
  logic [DataW-1:0] rain_total_r, rain_total_nxt;
  logic [DataW-1:0] wind_last_r, wind_last_nxt;
  logic [DataW-1:0] rain_last_r, rain_last_nxt;
  logic [DataW-1:0] gap_r, gap_nxt;
  res_t             res_r, res_nxt;

  logic [DataW-1:0] wind_dt;
  logic [DataW-1:0] rain_dt;
  logic             wind_prev;
  logic             rain_prev;
  logic             wind_ok;
  logic             rain_ok;
  logic             took;

  assign wind_dt   = time_us - wind_last_r;
  assign rain_dt   = time_us - rain_last_r;
  assign wind_prev = (wind_last_r != '0);
  assign rain_prev = (rain_last_r != '0);
  // a zero last time means no previous edge: never too soon
  assign wind_ok   = cfg.enable && !(wind_prev && (wind_dt < cfg.wind_holdoff_us));
  assign rain_ok   = cfg.enable && !(rain_prev && (rain_dt < cfg.rain_holdoff_us));

  always_comb begin
    wind_total_nxt = wind_total_r;
    rain_total_nxt = rain_total_r;
    wind_last_nxt  = wind_last_r;
    rain_last_nxt  = rain_last_r;
    gap_nxt        = gap_r;
    took           = 1'b0;
    case (op)
      OP_WIND: begin
        if (wind_ok) begin
          wind_total_nxt = wind_total_r + DataW'(1);
          if (wind_prev && (wind_dt < gap_r)) begin
            gap_nxt = wind_dt;
          end
          wind_last_nxt = time_us;
          took          = 1'b1;
        end
      end
      OP_RAIN: begin
        if (rain_ok) begin
          rain_total_nxt = rain_total_r + DataW'(1);
          rain_last_nxt  = time_us;
          took           = 1'b1;
        end
      end
      OP_CLEAR: begin
        wind_total_nxt = '0;
        rain_total_nxt = '0;
        gap_nxt        = GAP_NONE;
      end
      OP_START: begin
        wind_total_nxt = '0;
        rain_total_nxt = '0;
        gap_nxt        = GAP_NONE;
        wind_last_nxt  = time_us;
        rain_last_nxt  = '0;
      end
      default: begin
        took = 1'b0;
      end
    endcase
    res_nxt.wind_count      = wind_total_nxt;
    res_nxt.rain_count      = rain_total_nxt;
    res_nxt.shortest_gap_us = gap_nxt;
    res_nxt.accepted        = took;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_total_r <= '0;
      rain_total_r <= '0;
      wind_last_r  <= '0;
      rain_last_r  <= '0;
      gap_r        <= GAP_NONE;
    end else if (go) begin
      wind_total_r <= wind_total_nxt;
      rain_total_r <= rain_total_nxt;
      wind_last_r  <= wind_last_nxt;
      rain_last_r  <= rain_last_nxt;
      gap_r        <= gap_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    go && (op == OP_CLEAR || op == OP_START) |=>
      res_r.wind_count == '0 && res_r.rain_count == '0 &&
      res_r.shortest_gap_us == GAP_NONE && !res_r.accepted)
    else $error("clear or start left counts or gap behind");

  a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
    go && !cfg.enable && (op == OP_WIND || op == OP_RAIN) |=>
      !res_r.accepted && $stable(wind_total_r) && $stable(rain_total_r))
    else $error("edge counted while disabled");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(wind_total_r) && $stable(rain_total_r) &&
      $stable(wind_last_r) && $stable(gap_r))
    else $error("state moved without an item");

  a_gap_falls: assert property (@(posedge clk) disable iff (!rst_n)
    go && (op == OP_WIND || op == OP_RAIN) |=> gap_r <= $past(gap_r))
    else $error("shortest gap grew on an edge");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> res_r.wind_count == wind_total_r && res_r.shortest_gap_us == gap_r)
    else $error("result out of step with state");

endmodule

`default_nettype wire

>>> hw/rtl/pulse_debounce_counter_min_interval.sv
// Top level of the wind and rain pulse debounce counter.
// Input register, configuration registers, evaluation and result register.
// Depends on pdc_pkg, pdc_cfg and pdc_eval.
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------------------
//   in      | in_valid / in_stall       | in_op, in_time_us
//   out     | out_valid / out_stall     | out_wind_count, out_rain_count,
//           |                           | out_shortest_gap_us, out_accepted
//   cfg     | cfg_wr_en                 | cfg_index, cfg_data
//
// One item per cycle while out is not stalled; out_valid rises as an item moves
// from the input register to the result register, state updated with it.
// Synchronous active-low reset clears both valid bits, counts and times, sets
// the gap to GAP_NONE and loads config reset values. A stall on a valid out
// holds the result register, and a full input register is held and raises in_stall.
`default_nettype none

module pulse_debounce_counter_min_interval
  import pdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [OpW-1:0]     in_op,
  input  wire logic [DataW-1:0]   in_time_us,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [DataW-1:0]   out_wind_count,
  output      logic [DataW-1:0]   out_rain_count,
  output      logic [DataW-1:0]   out_shortest_gap_us,
  output      logic               out_accepted,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [DataW-1:0]   cfg_data
);

  logic             s1_valid_r;
  logic [OpW-1:0]   s1_op_r;
  logic [DataW-1:0] s1_time_r;
  logic             out_valid_r;
  logic             out_free;
  logic             go;
  logic             in_take;
  cfg_t             cfg;
  res_t             res;

  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_time_r <= in_time_us;
    end
  end

  pdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdc_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .go      (go),
    .op      (s1_op_r),
    .time_us (s1_time_r),
    .res     (res)
  );

  assign out_valid           = out_valid_r;
  assign out_wind_count      = res.wind_count;
  assign out_rain_count      = res.rain_count;
  assign out_shortest_gap_us = res.shortest_gap_us;
  assign out_accepted        = res.accepted;

endmodule

`default_nettype wire
